[design/mavg_pkg.sv]
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared types and constants for the moving average block with its
// invalid-sample guard.
// ----------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned WSIZE_W     = 5;
  localparam int unsigned LIMIT_W     = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_LIMIT = 1'd1;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd3;
  localparam logic [LIMIT_W-1:0] RUN_MAX     = 8'd255;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_invalid;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          out_sample_valid;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          average_valid;
    logic                          window_cleared;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT_RD,
    S_EVICT_SUB,
    S_PUSH,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

[design/mavg_ram.sv]
// ----------------------------------------------------------------------------
// mavg_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[design/mavg_div.sv]
// ----------------------------------------------------------------------------
// mavg_div
// Bit-serial restoring divider: signed dividend by unsigned divisor, one
// quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_div #(
  parameter int unsigned DIVIDEND_W = 36,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [DIVIDEND_W-1:0] dividend_i,
  input  wire logic        [DIVISOR_W-1:0]  divisor_i,
  output logic                              done_o,
  output logic signed      [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  div_q, div_d;
  logic                  neg_q, neg_d;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W);
      quo_d  = dividend_i[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend_i) : DIVIDEND_W'(dividend_i);
      rem_d  = '0;
      div_d  = divisor_i;
      neg_d  = dividend_i[DIVIDEND_W-1];
    end else if (busy_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      rem_d = fits ? DIVISOR_W'(trial - {1'b0, div_q}) : DIVISOR_W'(trial);
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? DIVIDEND_W'(-quo_q) : DIVIDEND_W'(quo_q);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");

  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider busy with zero count");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && $past(busy_q) |-> rem_q < div_q) else $error("remainder not below divisor");

endmodule

`default_nettype wire

[design/moving_average_invalid_guard_top.sv]
// ----------------------------------------------------------------------------
// moving_average_invalid_guard_top
// Sliding-window mean of Q16.16 sensor samples with an invalid-sample guard.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one sample per
// transaction; output channel (out_valid_o/out_ready_i/out_data_o) returns
// exactly one result per input transaction, in order.
// A valid sample passes through eviction (a RAM read and a subtract for each
// entry evicted, usually one), the push into the window and the bit-serial
// divider of the running sum by the fill count. in_ready_o is high only
// while the sequencer is idle.
// A finished result sits in the output register while the next sample is
// taken in; if the receiver still stalls when that one is done, the
// sequencer holds it until the register frees.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once.
// The user must make them only while the block is idle; it is not enforced.
// Reset empties the window, clears the invalid run and marks the average
// invalid; window size 16 and invalid limit 3. The window RAM needs no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_invalid_guard_top #(
  parameter int unsigned WINDOW_MAX = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire mavg_pkg::in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output mavg_pkg::out_t                       out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [mavg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mavg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import mavg_pkg::*;

  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);

  state_e                   state_q, state_d;
  logic [WSIZE_W-1:0]       wsize_q;
  logic [LIMIT_W-1:0]       limit_q;
  logic [CNT_W-1:0]         fill_q, fill_d;
  logic [PTR_W-1:0]         ptr_q, ptr_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [LIMIT_W-1:0]       run_q, run_d;
  logic signed [SAMPLE_BITS-1:0] mean_q, mean_d;
  logic                     mean_valid_q, mean_valid_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] smp_q, smp_d;
  out_t                     res_q, res_d;
  out_t                     out_q, out_d;

  logic [CNT_W-1:0]         size_eff;
  logic [LIMIT_W-1:0]       run_inc;
  logic [CNT_W:0]           waddr_sum;
  logic [PTR_W-1:0]         waddr;
  logic                     ram_we;
  logic [SAMPLE_BITS-1:0]   ram_rdata;
  logic signed [SAMPLE_BITS-1:0] old_smp;
  logic                     div_start;
  logic                     div_done;
  logic signed [SUM_W-1:0]  div_quo;

  always_comb begin
    if (wsize_q == '0) begin
      size_eff = CNT_W'(1);
    end else if (32'(wsize_q) > 32'(WINDOW_MAX)) begin
      size_eff = CNT_W'(WINDOW_MAX);
    end else begin
      size_eff = CNT_W'(wsize_q);
    end
  end

  assign run_inc   = (run_q < RUN_MAX) ? run_q + LIMIT_W'(1) : run_q;
  assign waddr_sum = (CNT_W + 1)'(ptr_q) + (CNT_W + 1)'(fill_q);
  assign waddr     = (32'(waddr_sum) >= 32'(WINDOW_MAX))
                   ? PTR_W'(waddr_sum - (CNT_W + 1)'(WINDOW_MAX)) : PTR_W'(waddr_sum);
  assign old_smp   = signed'(ram_rdata);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    ptr_d        = ptr_q;
    sum_d        = sum_q;
    run_d        = run_q;
    mean_d       = mean_q;
    mean_valid_d = mean_valid_q;
    out_valid_d  = out_valid_q;
    smp_d        = smp_q;
    res_d        = res_q;
    out_d        = out_q;
    in_ready_o   = 1'b0;
    ram_we       = 1'b0;
    div_start    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          smp_d = in_data_i.sample;
          if (!in_data_i.sample_invalid) begin
            run_d   = '0;
            state_d = S_EVICT_RD;
          end else if (run_inc < limit_q) begin
            run_d                  = run_inc;
            res_d.out_sample       = mean_q;
            res_d.out_sample_valid = mean_valid_q;
            res_d.average          = mean_valid_q ? mean_q : '0;
            res_d.average_valid    = mean_valid_q;
            res_d.window_cleared   = 1'b0;
            state_d                = S_FINISH;
          end else begin
            run_d                  = '0;
            fill_d                 = '0;
            ptr_d                  = '0;
            sum_d                  = '0;
            mean_d                 = '0;
            mean_valid_d           = 1'b0;
            res_d.out_sample       = in_data_i.sample;
            res_d.out_sample_valid = 1'b0;
            res_d.average          = '0;
            res_d.average_valid    = 1'b0;
            res_d.window_cleared   = 1'b1;
            state_d                = S_FINISH;
          end
        end
      end
      S_EVICT_RD: begin
        if (fill_q >= size_eff && fill_q != '0) begin
          state_d = S_EVICT_SUB;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_EVICT_SUB: begin
        sum_d   = sum_q - SUM_W'(old_smp);
        ptr_d   = (32'(ptr_q) == WINDOW_MAX - 1) ? '0 : ptr_q + PTR_W'(1);
        fill_d  = fill_q - CNT_W'(1);
        state_d = S_EVICT_RD;
      end
      S_PUSH: begin
        ram_we  = 1'b1;
        sum_d   = sum_q + SUM_W'(smp_q);
        fill_d  = fill_q + CNT_W'(1);
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          mean_d                 = div_quo[SAMPLE_BITS-1:0];
          mean_valid_d           = 1'b1;
          res_d.out_sample       = smp_q;
          res_d.out_sample_valid = 1'b1;
          res_d.average          = div_quo[SAMPLE_BITS-1:0];
          res_d.average_valid    = 1'b1;
          res_d.window_cleared   = 1'b0;
          state_d                = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q      <= WSIZE_RESET;
      limit_q      <= LIMIT_RESET;
      fill_q       <= '0;
      ptr_q        <= '0;
      sum_q        <= '0;
      run_q        <= '0;
      mean_q       <= '0;
      mean_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      fill_q       <= fill_d;
      ptr_q        <= ptr_d;
      sum_q        <= sum_d;
      run_q        <= run_d;
      mean_q       <= mean_d;
      mean_valid_q <= mean_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WINDOW_SIZE:   wsize_q <= cfg_data_i[WSIZE_W-1:0];
          CFG_INVALID_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  mavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (smp_q),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  mavg_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(WINDOW_MAX)) else $error("fill count beyond window");

  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == '0 |-> sum_q == '0) else $error("empty window with nonzero sum");

  a_mean_inval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mean_valid_q |-> mean_q == '0) else $error("invalid mean not zero");

  a_div_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV_WAIT |-> fill_q != '0) else $error("division by empty window");

endmodule

`default_nettype wire
